// ===== rtl/sfdc_pkg.sv =====
package sfdc_pkg;

    localparam int DATA_BYTES     = 4;
    localparam int NODE_ID_BYTES  = 4;
    localparam int CHECKSUM_CHARS = 4;
    localparam int MESSAGE_BYTES  = 16;

    localparam int BYTE_W   = 8;
    localparam int SUM_W    = 16;
    localparam int MOD_W    = SUM_W + 1;
    localparam int FIELD_W  = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 7;
    localparam int POS_MAX  = (1 << POS_W) - 1;

    localparam int FIELD_MAX_A = (DATA_BYTES > NODE_ID_BYTES) ? DATA_BYTES : NODE_ID_BYTES;
    localparam int FIELD_MAX   = (FIELD_MAX_A > CHECKSUM_CHARS) ? FIELD_MAX_A : CHECKSUM_CHARS;
    localparam int FCNT_W      = $clog2(FIELD_MAX + 1);
    localparam int DIV_CNT_W   = $clog2(SUM_W);

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = MOD_W;

    localparam logic [CFG_INDEX_W-1:0] REG_START_CHAR = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_TYPE  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HUM_TYPE   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MODULUS    = 2'd3;

    localparam logic [BYTE_W-1:0] START_CHAR_RESET = 8'd35;
    localparam logic [BYTE_W-1:0] TEMP_TYPE_RESET  = 8'd84;
    localparam logic [MOD_W-1:0]  MODULUS_RESET    = 17'd65536;

    localparam logic [STATUS_W-1:0] STATUS_VALID      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISMATCH   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_INCOMPLETE = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              buffer_end;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   frame_type;
        logic [FIELD_W-1:0]  payload;
        logic [FIELD_W-1:0]  node_ident;
        logic [SUM_W-1:0]    received_sum;
        logic [SUM_W-1:0]    computed_sum;
    } out_item_t;

endpackage

// ===== rtl/sensor_frame_deframer_checker_top.sv =====
// Sensor frame deframer and checksum checker. Bytes of a message buffer enter one per
// transaction; buffer_end marks the last byte. A start character is looked for only
// among the first MESSAGE_BYTES bytes of a buffer; the type, data, node-id and ASCII
// hex checksum characters follow. An ordinary byte does not stall the input. The byte
// whose arrival completes a frame starts a bit-serial restoring remainder unit that
// reduces the 16-bit byte sum by the modulus register one bit per cycle; the input
// stalls while it runs. Its result goes to a holding register and then to the output
// register. A byte that ends a buffer before the frame completes puts its result
// straight into the holding register. The input stalls whenever the holding register
// is full, so a waiting result stalls the input until it moves on to the output
// register. One result comes per buffer: valid or mismatch when the frame completes,
// incomplete at the buffer end otherwise. A modulus of zero or of 65536 and above
// leaves the sum unreduced. The humidity type register is accepted but changes no
// result.
module sensor_frame_deframer_checker_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  sfdc_pkg::in_item_t                  in_data,
    output logic                                in_stall,
    output logic                                out_valid,
    output sfdc_pkg::out_item_t                 out_data,
    input  logic                                out_stall,
    input  logic                                cfg_we,
    input  logic [sfdc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sfdc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_TYPE,
        PH_DATA,
        PH_NODE,
        PH_CSUM,
        PH_DONE
    } phase_t;

    typedef enum logic {
        ST_RUN,
        ST_MOD
    } state_t;

    function automatic logic [4:0] hex_digit(input logic [sfdc_pkg::BYTE_W-1:0] c);
        logic [4:0] r;
        r = 5'b0;
        if (c >= 8'd48 && c <= 8'd57) begin
            r = {1'b1, 4'(c - 8'd48)};
        end
        else if (c >= 8'd97 && c <= 8'd102) begin
            r = {1'b1, 4'(c - 8'd87)};
        end
        else if (c >= 8'd65 && c <= 8'd70) begin
            r = {1'b1, 4'(c - 8'd55)};
        end
        return r;
    endfunction

    logic [sfdc_pkg::BYTE_W-1:0]    start_char_reg, start_char_next;
    logic [sfdc_pkg::BYTE_W-1:0]    temp_type_reg, temp_type_next;
    logic [sfdc_pkg::MOD_W-1:0]     modulus_reg, modulus_next;

    state_t                         state_reg, state_next;
    phase_t                         phase_reg, phase_next;
    logic [sfdc_pkg::FCNT_W-1:0]    fcnt_reg, fcnt_next;
    logic [sfdc_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [sfdc_pkg::SUM_W-1:0]     sum_reg, sum_next;
    logic [sfdc_pkg::BYTE_W-1:0]    type_reg, type_next;
    logic [sfdc_pkg::FIELD_W-1:0]   payload_reg, payload_next;
    logic [sfdc_pkg::FIELD_W-1:0]   node_reg, node_next;
    logic [sfdc_pkg::SUM_W-1:0]     hex_reg, hex_next;
    logic                           hex_stopped_reg, hex_stopped_next;

    logic [sfdc_pkg::SUM_W-1:0]     div_sum_reg, div_sum_next;
    logic [sfdc_pkg::MOD_W-1:0]     rem_reg, rem_next;
    logic [sfdc_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    logic                           res_valid_reg, res_valid_next;
    sfdc_pkg::out_item_t            res_data_reg, res_data_next;
    logic                           out_valid_reg, out_valid_next;
    sfdc_pkg::out_item_t            out_data_reg, out_data_next;

    logic                           accept;
    logic                           complete;
    logic                           last;
    logic [sfdc_pkg::BYTE_W-1:0]    b;
    logic [4:0]                     hd;
    logic [sfdc_pkg::FCNT_W-1:0]    fcnt_inc;
    logic [sfdc_pkg::SUM_W-1:0]     sum_add;
    logic [sfdc_pkg::MOD_W-1:0]     rem_shift;

    assign in_stall  = (state_reg != ST_RUN) || res_valid_reg;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign b         = in_data.rx_byte;
    assign last      = in_data.buffer_end;
    assign hd        = hex_digit(b);
    assign fcnt_inc  = fcnt_reg + 1'b1;
    assign sum_add   = sum_reg + {{(sfdc_pkg::SUM_W - sfdc_pkg::BYTE_W){1'b0}}, b};
    assign rem_shift = {rem_reg[sfdc_pkg::SUM_W-1:0], div_sum_reg[sfdc_pkg::SUM_W-1]};

    always_comb
    begin
        start_char_next  = start_char_reg;
        temp_type_next   = temp_type_reg;
        modulus_next     = modulus_reg;
        state_next       = state_reg;
        phase_next       = phase_reg;
        fcnt_next        = fcnt_reg;
        pos_next         = pos_reg;
        sum_next         = sum_reg;
        type_next        = type_reg;
        payload_next     = payload_reg;
        node_next        = node_reg;
        hex_next         = hex_reg;
        hex_stopped_next = hex_stopped_reg;
        div_sum_next     = div_sum_reg;
        rem_next         = rem_reg;
        div_cnt_next     = div_cnt_reg;
        res_valid_next   = res_valid_reg;
        res_data_next    = res_data_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        complete         = 1'b0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                sfdc_pkg::REG_START_CHAR: start_char_next = cfg_data[sfdc_pkg::BYTE_W-1:0];
                sfdc_pkg::REG_TEMP_TYPE:  temp_type_next  = cfg_data[sfdc_pkg::BYTE_W-1:0];
                sfdc_pkg::REG_HUM_TYPE:   ;
                sfdc_pkg::REG_MODULUS:    modulus_next    = cfg_data;
                default:                  ;
            endcase
        end

        // drop the result once the transaction completes
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // advance the held result as soon as the output register frees up
        if (res_valid_reg && (!out_valid_reg || !out_stall))
        begin
            out_valid_next = 1'b1;
            out_data_next  = res_data_reg;
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_RUN:
            begin
                if (accept)
                begin
                    if (pos_reg != sfdc_pkg::POS_W'(sfdc_pkg::POS_MAX))
                    begin
                        pos_next = pos_reg + 1'b1;
                    end

                    unique case (phase_reg)
                        PH_HUNT:
                        begin
                            if (pos_reg < sfdc_pkg::POS_W'(sfdc_pkg::MESSAGE_BYTES)
                                && b == start_char_reg)
                            begin
                                sum_next   = {{(sfdc_pkg::SUM_W - sfdc_pkg::BYTE_W){1'b0}},
                                              start_char_reg};
                                phase_next = PH_TYPE;
                            end
                        end
                        PH_TYPE:
                        begin
                            type_next  = b;
                            sum_next   = sum_add;
                            fcnt_next  = '0;
                            phase_next = PH_DATA;
                        end
                        PH_DATA:
                        begin
                            payload_next = {payload_reg[sfdc_pkg::FIELD_W-sfdc_pkg::BYTE_W-1:0],
                                            b};
                            // temperature data counts twice
                            if (type_reg == temp_type_reg)
                            begin
                                sum_next = sum_add
                                    + {{(sfdc_pkg::SUM_W - sfdc_pkg::BYTE_W){1'b0}}, b};
                            end
                            else
                            begin
                                sum_next = sum_add;
                            end
                            fcnt_next = fcnt_inc;
                            if (fcnt_inc >= sfdc_pkg::FCNT_W'(sfdc_pkg::DATA_BYTES))
                            begin
                                fcnt_next  = '0;
                                phase_next = PH_NODE;
                            end
                        end
                        PH_NODE:
                        begin
                            node_next = {node_reg[sfdc_pkg::FIELD_W-sfdc_pkg::BYTE_W-1:0], b};
                            sum_next  = sum_add;
                            fcnt_next = fcnt_inc;
                            if (fcnt_inc >= sfdc_pkg::FCNT_W'(sfdc_pkg::NODE_ID_BYTES))
                            begin
                                fcnt_next  = '0;
                                phase_next = PH_CSUM;
                            end
                        end
                        PH_CSUM:
                        begin
                            if (!hex_stopped_reg)
                            begin
                                if (!hd[4])
                                begin
                                    hex_stopped_next = 1'b1;
                                end
                                else
                                begin
                                    hex_next = {hex_reg[sfdc_pkg::SUM_W-5:0], hd[3:0]};
                                end
                            end
                            fcnt_next = fcnt_inc;
                            if (fcnt_inc >= sfdc_pkg::FCNT_W'(sfdc_pkg::CHECKSUM_CHARS))
                            begin
                                fcnt_next  = '0;
                                complete   = 1'b1;
                                phase_next = PH_DONE;
                            end
                        end
                        default: ;
                    endcase

                    if (complete)
                    begin
                        // capture fields now; the frame may clear on this byte
                        res_data_next.frame_type   = type_next;
                        res_data_next.payload      = payload_next;
                        res_data_next.node_ident   = node_next;
                        res_data_next.received_sum = hex_next;
                        div_sum_next               = sum_next;
                        rem_next                   = '0;
                        div_cnt_next               = '0;
                        state_next                 = ST_MOD;
                    end
                    else if (last && phase_next != PH_DONE)
                    begin
                        res_data_next.status       = sfdc_pkg::STATUS_INCOMPLETE;
                        res_data_next.frame_type   = type_next;
                        res_data_next.payload      = '0;
                        res_data_next.node_ident   = '0;
                        res_data_next.received_sum = '0;
                        res_data_next.computed_sum = '0;
                        res_valid_next             = 1'b1;
                    end

                    if (last)
                    begin
                        phase_next       = PH_HUNT;
                        fcnt_next        = '0;
                        sum_next         = '0;
                        type_next        = '0;
                        payload_next     = '0;
                        node_next        = '0;
                        hex_next         = '0;
                        hex_stopped_next = 1'b0;
                        pos_next         = '0;
                    end
                end
            end
            ST_MOD:
            begin
                // one restoring remainder step per cycle
                if (rem_shift >= modulus_reg)
                begin
                    rem_next = rem_shift - modulus_reg;
                end
                else
                begin
                    rem_next = rem_shift;
                end
                div_sum_next = {div_sum_reg[sfdc_pkg::SUM_W-2:0], 1'b0};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == sfdc_pkg::DIV_CNT_W'(sfdc_pkg::SUM_W - 1))
                begin
                    res_data_next.computed_sum = rem_next[sfdc_pkg::SUM_W-1:0];
                    res_data_next.status = (res_data_reg.received_sum
                                            == rem_next[sfdc_pkg::SUM_W-1:0])
                                           ? sfdc_pkg::STATUS_VALID
                                           : sfdc_pkg::STATUS_MISMATCH;
                    res_valid_next = 1'b1;
                    state_next     = ST_RUN;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_char_reg  <= sfdc_pkg::START_CHAR_RESET;
            temp_type_reg   <= sfdc_pkg::TEMP_TYPE_RESET;
            modulus_reg     <= sfdc_pkg::MODULUS_RESET;
            state_reg       <= ST_RUN;
            phase_reg       <= PH_HUNT;
            fcnt_reg        <= '0;
            pos_reg         <= '0;
            sum_reg         <= '0;
            type_reg        <= '0;
            payload_reg     <= '0;
            node_reg        <= '0;
            hex_reg         <= '0;
            hex_stopped_reg <= 1'b0;
            div_sum_reg     <= '0;
            rem_reg         <= '0;
            div_cnt_reg     <= '0;
            res_valid_reg   <= 1'b0;
            res_data_reg    <= '0;
            out_valid_reg   <= 1'b0;
            out_data_reg    <= '0;
        end
        else
        begin
            start_char_reg  <= start_char_next;
            temp_type_reg   <= temp_type_next;
            modulus_reg     <= modulus_next;
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            fcnt_reg        <= fcnt_next;
            pos_reg         <= pos_next;
            sum_reg         <= sum_next;
            type_reg        <= type_next;
            payload_reg     <= payload_next;
            node_reg        <= node_next;
            hex_reg         <= hex_next;
            hex_stopped_reg <= hex_stopped_next;
            div_sum_reg     <= div_sum_next;
            rem_reg         <= rem_next;
            div_cnt_reg     <= div_cnt_next;
            res_valid_reg   <= res_valid_next;
            res_data_reg    <= res_data_next;
            out_valid_reg   <= out_valid_next;
            out_data_reg    <= out_data_next;
        end
    end

endmodule
